// ===== sv/mcc_pkg.sv =====
`timescale 1ns / 1ps

package mcc_pkg;

	// Table and coin geometry
	localparam int MAX_SUM   = 1023;
	localparam int MAX_COINS = 6;

	localparam int VAL_W     = 10;
	localparam int CNT_W     = 3;
	localparam int ENT_W     = 11;
	localparam int CFG_IDX_W = 3;
	localparam int DEPTH     = MAX_SUM + 1;
	localparam int SUM_W     = $clog2(DEPTH);
	localparam int CMP_W     = (SUM_W > VAL_W) ? SUM_W : VAL_W;
	localparam int SLOT_W    = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;

	// Entry marking a sum that no coin mix reaches
	localparam logic [ENT_W-1:0] UNREACH = {ENT_W{1'b1}};

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COIN_COUNT   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COIN_VALUE_0 = 3'd1;

	// Reset denominations
	localparam logic [VAL_W-1:0] COIN_RESET [6] = '{10'd1, 10'd2, 10'd5, 10'd10, 10'd20, 10'd50};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_ISSUE,
		ST_DRAIN,
		ST_DONE
	} state_t;

endpackage

// ===== sv/min_coin_change_core.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                Payload
// in        in_valid / in_stall      target_sum
// out       out_valid / out_stall    min_coins, reachable
// cfg       cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A query for target T walks each sum from 1 to T: it steps through every coin
// slot (MAX_COINS slots), issuing a table read through the single read port of
// the table memory for each active slot whose coin fits, then writes its entry.
// Reset clears the control state and loads the default denominations; the
// table memory needs no clearing, since every query rewrites what it reads.
// The next query is taken while a finished result waits under out_stall.
module min_coin_change_core
	import mcc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [VAL_W-1:0]     target_sum,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [VAL_W-1:0]     min_coins,
	output logic                 reachable,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  count_q;
	logic [VAL_W-1:0]  coin_q [MAX_COINS];
	logic [VAL_W-1:0]  target_q;
	logic              over_q;
	logic [SUM_W-1:0]  sum_q;
	logic [SLOT_W-1:0] slot_q;
	logic [ENT_W-1:0]  best_q;
	logic              rd_vld_s1;
	logic [ENT_W-1:0]  rd_data_s1;
	logic              out_valid_q;
	logic [VAL_W-1:0]  min_coins_q;
	logic              reachable_q;

	logic [ENT_W-1:0]  mem [DEPTH];

	logic              in_xfer;
	logic              cfg_xfer;
	logic              out_free;
	logic              slot_last;
	logic              slot_active;
	logic              sum_last;
	logic [VAL_W-1:0]  coin;
	logic              coin_fits;
	logic [ENT_W-1:0]  cand;
	logic [ENT_W-1:0]  best_next;
	logic              rd_en;
	logic [SUM_W-1:0]  rd_addr;
	logic              wr_en;
	logic [SUM_W-1:0]  wr_addr;
	logic [ENT_W-1:0]  wr_data;
	logic              load_out;

	assign cfg_ready = 1'b1;
	assign cfg_xfer  = cfg_valid && cfg_ready;
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// Per-slot read address and candidate
	assign coin        = coin_q[slot_q];
	assign slot_last   = (slot_q == SLOT_W'(MAX_COINS - 1));
	assign slot_active = (32'(slot_q) < 32'(count_q)) && (32'(slot_q) < MAX_COINS);
	assign coin_fits   = (coin != '0) && (CMP_W'(coin) <= CMP_W'(sum_q));
	assign rd_addr     = SUM_W'(CMP_W'(sum_q) - CMP_W'(coin));
	assign sum_last    = (CMP_W'(sum_q) == CMP_W'(target_q));
	assign cand        = rd_data_s1 + ENT_W'(1);

	// Fold the returning entry into the running minimum
	always_comb begin
		best_next = best_q;
		if (rd_vld_s1 && (rd_data_s1 != UNREACH) && (cand < best_q)) begin
			best_next = cand;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = (32'(target_sum) > MAX_SUM) ? ST_DONE : ST_INIT;
				end
			end
			ST_INIT: begin
				state_d = (target_q == '0) ? ST_DONE : ST_ISSUE;
			end
			ST_ISSUE: begin
				if (slot_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = sum_last ? ST_DONE : ST_ISSUE;
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		wr_addr  = sum_q;
		wr_data  = best_next;
		load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_INIT: begin
				wr_en   = 1'b1;
				wr_addr = '0;
				wr_data = '0;
			end
			ST_ISSUE: begin
				rd_en = slot_active && coin_fits;
			end
			ST_DRAIN: begin
				wr_en = 1'b1;
			end
			ST_DONE: begin
				load_out = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// Control and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_vld_s1 <= 1'b0;
			count_q   <= CNT_W'(1);
			for (int i = 0; i < MAX_COINS; i++) begin
				coin_q[i] <= (i < 6) ? COIN_RESET[i % 6] : VAL_W'(1);
			end
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= rd_en;
			// Apply a configuration transfer
			if (cfg_xfer) begin
				if (cfg_index == REG_COIN_COUNT) begin
					count_q <= cfg_data[CNT_W-1:0];
				end else if ((cfg_index >= REG_COIN_VALUE_0) &&
						(32'(cfg_index) <= MAX_COINS)) begin
					coin_q[SLOT_W'(cfg_index - REG_COIN_VALUE_0)] <= cfg_data;
				end
			end
			// Hold the result until its transfer, then drop or reload
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Sequencer datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			target_q <= target_sum;
			over_q   <= (32'(target_sum) > MAX_SUM);
			best_q   <= '0;
		end
		unique case (state_q)
			ST_INIT: begin
				sum_q  <= SUM_W'(1);
				slot_q <= '0;
				best_q <= (target_q == '0) ? '0 : UNREACH;
			end
			ST_ISSUE: begin
				best_q <= best_next;
				if (!slot_last) begin
					slot_q <= slot_q + SLOT_W'(1);
				end
			end
			ST_DRAIN: begin
				slot_q <= '0;
				if (sum_last) begin
					best_q <= best_next;
				end else begin
					best_q <= UNREACH;
					sum_q  <= sum_q + SUM_W'(1);
				end
			end
			default: begin
			end
		endcase
		// Load the output register
		if (load_out) begin
			if (over_q || (best_q == UNREACH)) begin
				min_coins_q <= '0;
				reachable_q <= 1'b0;
			end else begin
				min_coins_q <= best_q[VAL_W-1:0];
				reachable_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign min_coins = min_coins_q;
	assign reachable = reachable_q;

endmodule

// ===== sv/mcc_checker.sv =====
`timescale 1ns / 1ps

module mcc_checker
	import mcc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic [VAL_W-1:0]     target_sum,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [VAL_W-1:0]     min_coins,
	input logic                 reachable
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(min_coins) && $stable(reachable))
		else $error("stalled result changed");

	// An unreachable sum reports zero coins
	a_unreach_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !reachable |-> min_coins == '0)
		else $error("unreachable result with nonzero count");

	// The block is busy right after taking a query
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("query accepted while busy");

	// A new result appears only while a query is in flight
	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a query");

endmodule

bind min_coin_change_core mcc_checker u_mcc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.target_sum (target_sum),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.min_coins  (min_coins),
	.reachable  (reachable)
);
